// ----- rtl/jetp_pkg.sv -----
// Package for the Julia escape-time pixel block: field widths, register indexes,
// reset values, fixed-point constants and the controller/datapath interface types.
// No dependencies.
package jetp_pkg;

   localparam int MaxDimDefault     = 4096;
   localparam int CoordWidthDefault = 32;
   localparam int IterWidthDefault  = 16;

   localparam int PixelWidth    = 12;
   localparam int GrayWidth     = 8;
   localparam int CountWidth    = 16;
   localparam int CsrIndexWidth = 3;
   localparam int FracBits      = 27;
   localparam int NewWidth      = 40;

   localparam logic [CsrIndexWidth-1:0] RegXStart  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegXStep   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegYStart  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegYStep   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegCReal   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegCImag   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegMaxIter = 3'd6;

   localparam logic [31:0] StartReset   = 32'hF1F1_F8FC;
   localparam logic [31:0] StepReset    = 32'd919300;
   localparam logic [31:0] CReset       = 32'd0;
   localparam logic [15:0] MaxIterReset = 16'd256;

   localparam logic [31:0] FullScale = 32'd4228250625;
   localparam logic signed [NewWidth-1:0] EscBound = 40'sd268435456;
   localparam logic signed [63:0] CoordMax = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] CoordMin = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic [31:0] x_start;
      logic [31:0] x_step;
      logic [31:0] y_start;
      logic [31:0] y_step;
      logic [31:0] c_real;
      logic [31:0] c_imag;
      logic [15:0] max_iterations;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic coord_mul;
      logic coord_add;
      logic iter_mul;
      logic iter_upd;
      logic gray_full;
      logic rhs_mul;
      logic sq_mul;
      logic qu_mul;
      logic pm_mul;
      logic cmp;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic esc;
      logic last;
      logic max_zero;
      logic bit_last;
   } sts_type;

endpackage

// ----- rtl/jetp_csr.sv -----
// Configuration register file of the Julia escape-time pixel block.
// Depends on jetp_pkg.
module jetp_csr import jetp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_start        <= StartReset;
         cfg_ff.x_step         <= StepReset;
         cfg_ff.y_start        <= StartReset;
         cfg_ff.y_step         <= StepReset;
         cfg_ff.c_real         <= CReset;
         cfg_ff.c_imag         <= CReset;
         cfg_ff.max_iterations <= MaxIterReset;
      end else if (csr_valid) begin
         case (csr_index)
            RegXStart:  cfg_ff.x_start        <= csr_data;
            RegXStep:   cfg_ff.x_step         <= csr_data;
            RegYStart:  cfg_ff.y_start        <= csr_data;
            RegYStep:   cfg_ff.y_step         <= csr_data;
            RegCReal:   cfg_ff.c_real         <= csr_data;
            RegCImag:   cfg_ff.c_imag         <= csr_data;
            RegMaxIter: cfg_ff.max_iterations <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- rtl/jetp_ctrl.sv -----
// Controller of the Julia escape-time pixel block: sequences start point, iteration
// loop and fourth-root search, and owns the result handshake. Depends on jetp_pkg.
module jetp_ctrl import jetp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StCMul = 4'd1;
   localparam logic [3:0] StCAdd = 4'd2;
   localparam logic [3:0] StIMul = 4'd3;
   localparam logic [3:0] StIUpd = 4'd4;
   localparam logic [3:0] StRhs  = 4'd5;
   localparam logic [3:0] StSq   = 4'd6;
   localparam logic [3:0] StQu   = 4'd7;
   localparam logic [3:0] StPm   = 4'd8;
   localparam logic [3:0] StCmp  = 4'd9;
   localparam logic [3:0] StDone = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = StCMul;
            end
         end
         StCMul: begin
            cmd.coord_mul = 1'b1;
            state_in      = StCAdd;
         end
         StCAdd: begin
            cmd.coord_add = 1'b1;
            state_in      = sts.max_zero ? StDone : StIMul;
         end
         StIMul: begin
            cmd.iter_mul = 1'b1;
            state_in     = StIUpd;
         end
         StIUpd: begin
            cmd.iter_upd = 1'b1;
            if (sts.esc) begin
               cmd.gray_full = sts.last;
               state_in      = sts.last ? StDone : StRhs;
            end else begin
               state_in = sts.last ? StDone : StIMul;
            end
         end
         StRhs: begin
            cmd.rhs_mul = 1'b1;
            state_in    = StSq;
         end
         StSq: begin
            cmd.sq_mul = 1'b1;
            state_in   = StQu;
         end
         StQu: begin
            cmd.qu_mul = 1'b1;
            state_in   = StPm;
         end
         StPm: begin
            cmd.pm_mul = 1'b1;
            state_in   = StCmp;
         end
         StCmp: begin
            cmd.cmp  = 1'b1;
            state_in = sts.bit_last ? StDone : StSq;
         end
         StDone: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/jetp_dpath.sv -----
// Datapath of the Julia escape-time pixel block: start point, complex square unit,
// iteration counter, fourth-root search and result register. Depends on jetp_pkg.
module jetp_dpath import jetp_pkg::*; #(
   parameter int MAX_DIM     = MaxDimDefault,
   parameter int COORD_WIDTH = CoordWidthDefault,
   parameter int ITER_WIDTH  = IterWidthDefault
) (
   input  logic                  clock,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [PixelWidth-1:0] pixel_row,
   input  logic [PixelWidth-1:0] pixel_col,
   output logic [GrayWidth-1:0]  gray_level,
   output logic [CountWidth-1:0] escape_count,
   output logic                  escaped
);

   localparam int IdxWidth  = $clog2(MAX_DIM);
   localparam int ProdWidth = COORD_WIDTH + IdxWidth + 1;
   localparam int RhsWidth  = 32 + ITER_WIDTH;

   function automatic logic [IdxWidth-1:0] clamp_idx(input logic [PixelWidth-1:0] v);
      if (32'(v) > 32'(MAX_DIM - 1)) begin
         clamp_idx = IdxWidth'(MAX_DIM - 1);
      end else begin
         clamp_idx = IdxWidth'(v);
      end
   endfunction

   function automatic logic [31:0] sat32(input logic signed [COORD_WIDTH-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > CoordMax) begin
         sat32 = CoordMax[31:0];
      end else if (w < CoordMin) begin
         sat32 = CoordMin[31:0];
      end else begin
         sat32 = w[31:0];
      end
   endfunction

   logic [IdxWidth-1:0]           row_idx_ff, col_idx_ff;
   logic signed [COORD_WIDTH-1:0] prod_x_ff, prod_y_ff;
   logic signed [ProdWidth-1:0]   prod_x_in, prod_y_in;
   logic signed [COORD_WIDTH-1:0] sum_x, sum_y;
   logic signed [31:0]            x_ff, y_ff;
   logic signed [63:0]            xx_ff, yy_ff, xy_ff, diff;
   logic signed [NewWidth-1:0]    x_in, y_in;
   logic [ITER_WIDTH-1:0]         k_ff, count_ff, max_it;
   logic [RhsWidth-1:0]           rhs_ff, p_ff;
   logic [15:0]                   sq_ff;
   logic [31:0]                   q_ff;
   logic [GrayWidth-1:0]          g_ff, mask_ff, trial;
   logic [GrayWidth-1:0]          gray_out_ff;
   logic [CountWidth-1:0]         count_out_ff;
   logic                          escaped_out_ff;

   assign max_it = ITER_WIDTH'(cfg.max_iterations);

   assign prod_x_in = $signed(COORD_WIDTH'($signed(cfg.x_step))) * $signed({1'b0, col_idx_ff});
   assign prod_y_in = $signed(COORD_WIDTH'($signed(cfg.y_step))) * $signed({1'b0, row_idx_ff});
   assign sum_x = $signed(COORD_WIDTH'($signed(cfg.x_start))) + prod_x_ff;
   assign sum_y = $signed(COORD_WIDTH'($signed(cfg.y_start))) + prod_y_ff;

   assign diff = xx_ff - yy_ff;
   assign x_in = NewWidth'(diff >>> FracBits) + NewWidth'($signed(cfg.c_real));
   assign y_in = NewWidth'(xy_ff >>> (FracBits - 1)) + NewWidth'($signed(cfg.c_imag));

   assign trial = g_ff | mask_ff;

   assign sts.esc      = (x_in < -EscBound) || (x_in > EscBound) ||
                         (y_in < -EscBound) || (y_in > EscBound);
   assign sts.last     = (k_ff == max_it);
   assign sts.max_zero = (max_it == '0);
   assign sts.bit_last = mask_ff[0];

   assign gray_level   = gray_out_ff;
   assign escape_count = count_out_ff;
   assign escaped      = escaped_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_idx_ff <= clamp_idx(pixel_row);
         col_idx_ff <= clamp_idx(pixel_col);
         k_ff       <= ITER_WIDTH'(1);
         count_ff   <= '0;
         g_ff       <= '0;
         mask_ff    <= {1'b1, {(GrayWidth - 1){1'b0}}};
      end
      if (cmd.coord_mul) begin
         prod_x_ff <= prod_x_in[COORD_WIDTH-1:0];
         prod_y_ff <= prod_y_in[COORD_WIDTH-1:0];
      end
      if (cmd.coord_add) begin
         x_ff <= sat32(sum_x);
         y_ff <= sat32(sum_y);
      end
      if (cmd.iter_mul) begin
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         xy_ff <= x_ff * y_ff;
      end
      if (cmd.iter_upd) begin
         if (sts.esc) begin
            count_ff <= k_ff;
         end else begin
            x_ff <= x_in[31:0];
            y_ff <= y_in[31:0];
            k_ff <= k_ff + ITER_WIDTH'(1);
         end
      end
      if (cmd.gray_full) begin
         g_ff <= '1;
      end
      if (cmd.rhs_mul) begin
         rhs_ff <= RhsWidth'(FullScale) * RhsWidth'(count_ff);
      end
      if (cmd.sq_mul) begin
         sq_ff <= 16'(trial) * 16'(trial);
      end
      if (cmd.qu_mul) begin
         q_ff <= 32'(sq_ff) * 32'(sq_ff);
      end
      if (cmd.pm_mul) begin
         p_ff <= RhsWidth'(q_ff) * RhsWidth'(max_it);
      end
      if (cmd.cmp) begin
         if (p_ff <= rhs_ff) begin
            g_ff <= trial;
         end
         mask_ff <= mask_ff >> 1;
      end
      if (cmd.out_load) begin
         gray_out_ff    <= g_ff;
         count_out_ff   <= CountWidth'(count_ff);
         escaped_out_ff <= (count_ff != '0);
      end
   end

endmodule

// ----- rtl/julia_escape_time_pixel.sv -----
// Julia escape-time pixel: one gray level per pixel from its escape count.
// Sequence: start point, then the complex square loop for up to max_iterations iterations,
// then the fourth-root search when the gray level needs it (escape before the limit).
// Throughput: one pixel at a time; a new request is accepted only in the idle state.
// Reset: clears the controller and result valid, loads register defaults; no clearing pass.
// Depends on jetp_pkg, jetp_csr, jetp_ctrl, jetp_dpath.
module julia_escape_time_pixel import jetp_pkg::*; #(
   parameter int MAX_DIM     = MaxDimDefault,
   parameter int COORD_WIDTH = CoordWidthDefault,
   parameter int ITER_WIDTH  = IterWidthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [23:0]              req_tdata,   // pixel_row[11:0], pixel_col[23:12]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,   // gray_level[7:0], escape_count[23:8]
   output logic                     rsp_tuser,   // escaped[0]
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_data
);

   cfg_type               cfg;
   cmd_type               cmd;
   sts_type               sts;
   logic [GrayWidth-1:0]  gray_level;
   logic [CountWidth-1:0] escape_count;
   logic                  escaped;

   assign rsp_tdata = {escape_count, gray_level};
   assign rsp_tuser = escaped;

   jetp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   jetp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   jetp_dpath #(
      .MAX_DIM     (MAX_DIM),
      .COORD_WIDTH (COORD_WIDTH),
      .ITER_WIDTH  (ITER_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .cfg          (cfg),
      .cmd          (cmd),
      .sts          (sts),
      .pixel_row    (req_tdata[11:0]),
      .pixel_col    (req_tdata[23:12]),
      .gray_level   (gray_level),
      .escape_count (escape_count),
      .escaped      (escaped)
   );

endmodule
